>>> rtl/core/dsdu_pkg.sv
// ----------------------------------------------------------------------------
// dsdu_pkg
// Shared types and constants of the DSD frame unpack and downmix unit.
// ----------------------------------------------------------------------------
package dsdu_pkg;

   // frame geometry
   localparam int MAX_CHANNELS = 6;
   localparam int NUM_CHANNELS = 6;
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 3;

   // arithmetic widths
   localparam int WEIGHT_W  = 16;
   localparam int GAIN_W    = 20;
   localparam int TERM_W    = WEIGHT_W + 2;
   localparam int SUM_W     = WEIGHT_W + 3;
   localparam int MAG_W     = WEIGHT_W + 2;
   localparam int SAMPLE_W  = 17;
   localparam int CHCOUNT_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   // sample codes in signed Q.15
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_ONE = 17'sd32768;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_ONE = -17'sd32768;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_ZERO    = 17'sd0;

   // channel counts that allow a downmix
   localparam logic [CHCOUNT_W-1:0] CH_FIVE = 3'd5;
   localparam logic [CHCOUNT_W-1:0] CH_SIX  = 3'd6;

   // last bit position of a frame
   localparam logic [POS_W-1:0] POS_LAST = 3'd7;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIX_MODE      = 3'd0,
      CSR_CHANNEL_COUNT = 3'd1,
      CSR_FRONT_WEIGHT  = 3'd2,
      CSR_CENTRE_WEIGHT = 3'd3,
      CSR_SUB_WEIGHT    = 3'd4,
      CSR_REAR_WEIGHT   = 3'd5,
      CSR_MIX_GAIN      = 3'd6
   } csr_index_type;

   // reset values
   localparam logic [CHCOUNT_W-1:0] RST_CHANNEL_COUNT = 3'd6;
   localparam logic [WEIGHT_W-1:0]  RST_FRONT_WEIGHT  = 16'd32768;
   localparam logic [WEIGHT_W-1:0]  RST_CENTRE_WEIGHT = 16'd23170;
   localparam logic [WEIGHT_W-1:0]  RST_SUB_WEIGHT    = 16'd23170;
   localparam logic [WEIGHT_W-1:0]  RST_REAR_WEIGHT   = 16'd32768;
   localparam logic [GAIN_W-1:0]    RST_MIX_GAIN      = 20'd19195;

   // one bit slot after the weighted sums, before scaling
   typedef struct packed {
      logic                    mix;
      logic                    bad;
      logic                    last;
      logic                    neg_l;
      logic [MAG_W-1:0]        mag_l;
      logic                    neg_r;
      logic [MAG_W-1:0]        mag_r;
      logic [NUM_CHANNELS-1:0] chan_bit;
      logic [NUM_CHANNELS-1:0] chan_on;
   } slot_type;

endpackage

>>> rtl/core/dsdu_scale.sv
// ----------------------------------------------------------------------------
// dsdu_scale
// Scales a sign-magnitude mix sum by the Q4.16 gain, rounds half away from
// zero and saturates to a 17-bit signed sample.
// ----------------------------------------------------------------------------
module dsdu_scale
   import dsdu_pkg::*;
(
   input  logic [MAG_W-1:0]           mag,
   input  logic                       neg,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam int PROD_W  = MAG_W + GAIN_W;
   localparam int ROUND_W = PROD_W + 1;
   localparam int FRAC_W  = 16;
   localparam int RES_W   = ROUND_W - FRAC_W;

   localparam logic [ROUND_W-1:0]  HALF_LSB = ROUND_W'(32768);
   localparam logic [RES_W-1:0]    NEG_LIM  = RES_W'(65536);
   localparam logic [RES_W-1:0]    POS_LIM  = RES_W'(65535);

   logic [PROD_W-1:0]   prod;
   logic [ROUND_W-1:0]  rounded;
   logic [RES_W-1:0]    whole;
   logic [SAMPLE_W-1:0] neg_mag;
   logic [SAMPLE_W-1:0] pos_mag;

   // product and round to nearest on the magnitude
   assign prod    = PROD_W'(mag) * PROD_W'(gain);
   assign rounded = ROUND_W'(prod) + HALF_LSB;
   assign whole   = rounded[ROUND_W-1:FRAC_W];

   // clamp each sign to its own bound
   assign neg_mag = (whole > NEG_LIM) ? NEG_LIM[SAMPLE_W-1:0] : whole[SAMPLE_W-1:0];
   assign pos_mag = (whole > POS_LIM) ? POS_LIM[SAMPLE_W-1:0] : whole[SAMPLE_W-1:0];

   assign sample = neg ? -$signed(neg_mag) : $signed(pos_mag);

endmodule

>>> rtl/core/dsd_frame_unpack_downmix_unit.sv
// ----------------------------------------------------------------------------
// dsd_frame_unpack_downmix_unit
// DSD frame unpacker with 5/6 channel to stereo downmix.
// ----------------------------------------------------------------------------
// One req word carries one DSD frame, a byte per channel. The unit sends
// eight rsp words per frame, one per DSD bit, most significant bit first,
// and flags the eighth with last_of_frame. It sends one rsp word per clock
// while rsp_ready is high, and a new frame is taken in the cycle its
// predecessor's last bit leaves the frame register: with rsp_ready held high
// frames stream back to back. A frame's rsp words pass from the frame
// register through the sum stage, then the scale stage into the output
// register. In unpack mode each used channel bit becomes +1.0 or -1.0
// in Q.15; in mix mode out0/out1 carry the weighted stereo pair scaled
// by mix_gain (load it with the reciprocal of the weight sum), rounded and
// saturated. Mix mode with a channel count other than 5 or 6 returns zeros
// with bad_setup set. Write the csr registers only while the unit is idle;
// csr_ready is always high.
// ----------------------------------------------------------------------------
module dsd_frame_unpack_downmix_unit
   import dsdu_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data,
   // frame input
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_W-1:0]          req_chan0_byte,
   input  logic [BYTE_W-1:0]          req_chan1_byte,
   input  logic [BYTE_W-1:0]          req_chan2_byte,
   input  logic [BYTE_W-1:0]          req_chan3_byte,
   input  logic [BYTE_W-1:0]          req_chan4_byte,
   input  logic [BYTE_W-1:0]          req_chan5_byte,
   // results
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out0,
   output logic signed [SAMPLE_W-1:0] rsp_out1,
   output logic signed [SAMPLE_W-1:0] rsp_out2,
   output logic signed [SAMPLE_W-1:0] rsp_out3,
   output logic signed [SAMPLE_W-1:0] rsp_out4,
   output logic signed [SAMPLE_W-1:0] rsp_out5,
   output logic                       rsp_bad_setup,
   output logic                       rsp_last_of_frame
);

   // configuration registers
   logic                 mix_mode_ff;
   logic [CHCOUNT_W-1:0] channel_count_ff;
   logic [WEIGHT_W-1:0]  front_weight_ff;
   logic [WEIGHT_W-1:0]  centre_weight_ff;
   logic [WEIGHT_W-1:0]  sub_weight_ff;
   logic [WEIGHT_W-1:0]  rear_weight_ff;
   logic [GAIN_W-1:0]    mix_gain_ff;

   // frame register and bit position
   logic [NUM_CHANNELS-1:0][BYTE_W-1:0] frame_ff, frame_in;
   logic                                frame_valid_ff, frame_valid_in;
   logic [POS_W-1:0]                    pos_ff, pos_in;

   // sum stage
   slot_type slot_ff, slot_in;
   logic     slot_valid_ff, slot_valid_in;

   // output register
   logic signed [SAMPLE_W-1:0] out_ff [NUM_CHANNELS];
   logic signed [SAMPLE_W-1:0] out_in [NUM_CHANNELS];
   logic                       bad_ff, bad_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic out_adv, slot_adv, issue, frame_done, req_take;

   // pipeline flow control
   assign out_adv    = !rsp_valid_ff || rsp_ready;
   assign slot_adv   = !slot_valid_ff || out_adv;
   assign issue      = frame_valid_ff && slot_adv;
   assign frame_done = issue && (pos_ff == POS_LAST);
   assign req_ready  = !frame_valid_ff || frame_done;
   assign req_take   = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_mode_ff      <= 1'b0;
         channel_count_ff <= RST_CHANNEL_COUNT;
         front_weight_ff  <= RST_FRONT_WEIGHT;
         centre_weight_ff <= RST_CENTRE_WEIGHT;
         sub_weight_ff    <= RST_SUB_WEIGHT;
         rear_weight_ff   <= RST_REAR_WEIGHT;
         mix_gain_ff      <= RST_MIX_GAIN;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIX_MODE:      mix_mode_ff      <= csr_data[0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CHCOUNT_W-1:0];
            CSR_FRONT_WEIGHT:  front_weight_ff  <= csr_data[WEIGHT_W-1:0];
            CSR_CENTRE_WEIGHT: centre_weight_ff <= csr_data[WEIGHT_W-1:0];
            CSR_SUB_WEIGHT:    sub_weight_ff    <= csr_data[WEIGHT_W-1:0];
            CSR_REAR_WEIGHT:   rear_weight_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_MIX_GAIN:      mix_gain_ff      <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // frame register next state
   always_comb begin
      frame_in       = frame_ff;
      frame_valid_in = frame_valid_ff;
      pos_in         = issue ? pos_ff + 1'b1 : pos_ff;
      if (req_take) begin
         frame_in       = {req_chan5_byte, req_chan4_byte, req_chan3_byte,
                           req_chan2_byte, req_chan1_byte, req_chan0_byte};
         frame_valid_in = 1'b1;
      end else if (frame_done) begin
         frame_valid_in = 1'b0;
      end
   end

   // current bit of every channel
   logic [NUM_CHANNELS-1:0] cur_bit;
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         cur_bit[k] = frame_ff[k][POS_W'(BYTE_W - 1) - pos_ff];
      end
   end

   // signed weight term
   function automatic logic signed [TERM_W-1:0] term(input logic b,
                                                     input logic [WEIGHT_W-1:0] w);
      logic signed [TERM_W-1:0] wide;
      wide = $signed({2'b00, w});
      return b ? wide : -wide;
   endfunction

   // weighted sums and unpack mask
   logic                     six, bad_count;
   logic [CHCOUNT_W-1:0]     limit;
   logic signed [SUM_W-1:0]  mono, sum_l, sum_r;
   logic                     rear_l_bit, rear_r_bit;
   always_comb begin
      six       = (channel_count_ff == CH_SIX);
      bad_count = !(channel_count_ff inside {CH_FIVE, CH_SIX}) ||
                  (32'(channel_count_ff) > MAX_CHANNELS);
      limit     = (32'(channel_count_ff) > MAX_CHANNELS) ?
                  CHCOUNT_W'(MAX_CHANNELS) : channel_count_ff;
      rear_l_bit = six ? cur_bit[4] : cur_bit[3];
      rear_r_bit = six ? cur_bit[5] : cur_bit[4];
      mono = SUM_W'(term(cur_bit[2], centre_weight_ff));
      if (six) begin
         mono = mono + SUM_W'(term(cur_bit[3], sub_weight_ff));
      end
      sum_l = SUM_W'(term(cur_bit[0], front_weight_ff)) +
              SUM_W'(term(rear_l_bit, rear_weight_ff)) + mono;
      sum_r = SUM_W'(term(cur_bit[1], front_weight_ff)) +
              SUM_W'(term(rear_r_bit, rear_weight_ff)) + mono;

      slot_in.mix      = mix_mode_ff && !bad_count;
      slot_in.bad      = mix_mode_ff && bad_count;
      slot_in.last     = (pos_ff == POS_LAST);
      slot_in.neg_l    = sum_l[SUM_W-1];
      slot_in.mag_l    = sum_l[SUM_W-1] ? MAG_W'(-sum_l) : MAG_W'(sum_l);
      slot_in.neg_r    = sum_r[SUM_W-1];
      slot_in.mag_r    = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
      slot_in.chan_bit = cur_bit;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         slot_in.chan_on[k] = !mix_mode_ff && (32'(limit) > k);
      end
   end

   assign slot_valid_in = slot_adv ? issue : slot_valid_ff;

   // gain, rounding and saturation of the stereo pair
   logic signed [SAMPLE_W-1:0] mix_l, mix_r;

   dsdu_scale u_scale_l (
      .mag    (slot_ff.mag_l),
      .neg    (slot_ff.neg_l),
      .gain   (mix_gain_ff),
      .sample (mix_l)
   );

   dsdu_scale u_scale_r (
      .mag    (slot_ff.mag_r),
      .neg    (slot_ff.neg_r),
      .gain   (mix_gain_ff),
      .sample (mix_r)
   );

   // result word
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (slot_ff.chan_on[k]) begin
            out_in[k] = slot_ff.chan_bit[k] ? SAMPLE_POS_ONE : SAMPLE_NEG_ONE;
         end else begin
            out_in[k] = SAMPLE_ZERO;
         end
      end
      if (slot_ff.mix) begin
         out_in[0] = mix_l;
         out_in[1] = mix_r;
      end
      bad_in  = slot_ff.bad;
      last_in = slot_ff.last;
   end

   assign rsp_valid_in = out_adv ? slot_valid_ff : rsp_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         pos_ff         <= '0;
         slot_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_valid_ff <= frame_valid_in;
         pos_ff         <= pos_in;
         slot_valid_ff  <= slot_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (slot_adv && issue) begin
         slot_ff <= slot_in;
      end
      if (out_adv && slot_valid_ff) begin
         out_ff  <= out_in;
         bad_ff  <= bad_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out0          = out_ff[0];
   assign rsp_out1          = out_ff[1];
   assign rsp_out2          = out_ff[2];
   assign rsp_out3          = out_ff[3];
   assign rsp_out4          = out_ff[4];
   assign rsp_out5          = out_ff[5];
   assign rsp_bad_setup     = bad_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

>>> rtl/core/dsdu_checker.sv
// ----------------------------------------------------------------------------
// dsdu_checker
// Port-level checks of the DSD frame unpack and downmix unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module dsdu_checker
   import dsdu_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_out0,
   input logic signed [SAMPLE_W-1:0] rsp_out1,
   input logic signed [SAMPLE_W-1:0] rsp_out2,
   input logic signed [SAMPLE_W-1:0] rsp_out3,
   input logic signed [SAMPLE_W-1:0] rsp_out4,
   input logic signed [SAMPLE_W-1:0] rsp_out5,
   input logic                       rsp_bad_setup,
   input logic                       rsp_last_of_frame
);

   localparam int PEND_W = 5;

   logic              req_take, rsp_take;
   logic [POS_W-1:0]  rsp_count_ff;
   logic [PEND_W-1:0] pending_ff;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // words delivered within the frame, and words owed
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_count_ff <= '0;
         pending_ff   <= '0;
      end else begin
         if (rsp_take) begin
            rsp_count_ff <= rsp_count_ff + 1'b1;
         end
         pending_ff <= pending_ff + (req_take ? PEND_W'(8) : PEND_W'(0))
                                  - (rsp_take ? PEND_W'(1) : PEND_W'(0));
      end
   end

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out0) &&
      $stable(rsp_out1) && $stable(rsp_last_of_frame))
      else $error("rsp word changed while stalled");

   // last flag marks every eighth word
   a_last_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_of_frame == (rsp_count_ff == POS_LAST))
      else $error("last_of_frame out of place");

   // no word without an accepted frame behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("rsp word without a pending frame");

   // a bad setup gives silent samples
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_setup |-> rsp_out0 == '0 && rsp_out1 == '0 &&
      rsp_out2 == '0 && rsp_out3 == '0 && rsp_out4 == '0 && rsp_out5 == '0)
      else $error("nonzero sample with bad setup");

   // the side channel out3 only carries unpacked codes
   a_side_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out3 == SAMPLE_ZERO || rsp_out3 == SAMPLE_POS_ONE ||
      rsp_out3 == SAMPLE_NEG_ONE)
      else $error("unexpected code on out3");

endmodule

bind dsd_frame_unpack_downmix_unit dsdu_checker u_dsdu_checker (.*);

>>> sim/tb_dsd_frame_unpack_downmix_unit.sv
// ----------------------------------------------------------------------------
// tb_dsd_frame_unpack_downmix_unit
// Self-checking bench for the DSD frame unpack and stereo downmix unit.
// Frames go in on the req channel and the registers are loaded on the csr
// channel. An in-bench model of the unit turns every accepted frame into its
// eight expected bit words. Each rsp word is compared field by field with the
// oldest of them. The run has a directed part for both modes, for the bad
// channel counts, and for rounding and saturation. It goes on with random
// register settings and frames, a long output stall, and a back-to-back
// stretch at the end.
// ----------------------------------------------------------------------------
module tb_dsd_frame_unpack_downmix_unit
   import dsdu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES     = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 20;
   localparam int RANDOM_PHASES    = 12;

   // index with no register behind it, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef logic [NUM_CHANNELS-1:0][BYTE_W-1:0] frame_type;

   // one expected rsp word
   typedef struct packed {
      logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] sample;
      logic                                  bad;
      logic                                  last;
   } bit_word_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DAT_W-1:0]       csr_data;
   logic                       req_valid;
   logic                       req_ready;
   logic [BYTE_W-1:0]          req_chan0_byte;
   logic [BYTE_W-1:0]          req_chan1_byte;
   logic [BYTE_W-1:0]          req_chan2_byte;
   logic [BYTE_W-1:0]          req_chan3_byte;
   logic [BYTE_W-1:0]          req_chan4_byte;
   logic [BYTE_W-1:0]          req_chan5_byte;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_out0;
   logic signed [SAMPLE_W-1:0] rsp_out1;
   logic signed [SAMPLE_W-1:0] rsp_out2;
   logic signed [SAMPLE_W-1:0] rsp_out3;
   logic signed [SAMPLE_W-1:0] rsp_out4;
   logic signed [SAMPLE_W-1:0] rsp_out5;
   logic                       rsp_bad_setup;
   logic                       rsp_last_of_frame;

   // register copies seen by the model
   logic                 mode_cfg;
   logic [CHCOUNT_W-1:0] count_cfg;
   logic [WEIGHT_W-1:0]  front_cfg;
   logic [WEIGHT_W-1:0]  centre_cfg;
   logic [WEIGHT_W-1:0]  sub_cfg;
   logic [WEIGHT_W-1:0]  rear_cfg;
   logic [GAIN_W-1:0]    gain_cfg;

   bit_word_type pending_words[$];
   int           errors;
   int           cycle_count;
   bit           tx_bursts;
   bit           rx_bursts;
   bit           long_hold_req;

   dsd_frame_unpack_downmix_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_chan0_byte    (req_chan0_byte),
      .req_chan1_byte    (req_chan1_byte),
      .req_chan2_byte    (req_chan2_byte),
      .req_chan3_byte    (req_chan3_byte),
      .req_chan4_byte    (req_chan4_byte),
      .req_chan5_byte    (req_chan5_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out0          (rsp_out0),
      .rsp_out1          (rsp_out1),
      .rsp_out2          (rsp_out2),
      .rsp_out3          (rsp_out3),
      .rsp_out4          (rsp_out4),
      .rsp_out5          (rsp_out5),
      .rsp_bad_setup     (rsp_bad_setup),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run limit reached with %0d words outstanding",
                  $time, pending_words.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // model of the unit
   // ------------------------------------------------------------------------

   // +w for a set bit, -w for a clear one
   function automatic longint signed_weight(input logic b, input logic [WEIGHT_W-1:0] w);
      return b ? longint'(w) : -longint'(w);
   endfunction

   // gain, round half away from zero, then clamp to the 17 bit range
   function automatic logic [SAMPLE_W-1:0] scale_to_sample(input longint sum);
      longint mag;
      longint r;
      mag = (sum < 0) ? -sum : sum;
      r = (mag * longint'(gain_cfg) + 64'sd32768) >>> 16;
      if (r > 65536) r = 65536;
      if (sum < 0) r = -r;
      else if (r > 65535) r = 65535;
      return r[SAMPLE_W-1:0];
   endfunction

   // queue the eight bit words that one frame turns into
   function automatic void predict_frame(input frame_type frame);
      bit_word_type            word;
      logic [NUM_CHANNELS-1:0] bits;
      int                      limit;
      int                      rear_l;
      int                      rear_r;
      logic                    six;
      logic                    bad;
      longint                  mono;
      longint                  left;
      longint                  right;
      limit  = (count_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_cfg);
      bad    = (count_cfg != CH_FIVE) && (count_cfg != CH_SIX);
      six    = (count_cfg == CH_SIX);
      rear_l = six ? 4 : 3;
      rear_r = six ? 5 : 4;
      for (int pos = 0; pos < 8; pos++) begin
         word = '0;
         for (int ch = 0; ch < NUM_CHANNELS; ch++)
            bits[ch] = frame[ch][BYTE_W-1-pos];
         if (!mode_cfg) begin
            for (int ch = 0; ch < limit; ch++)
               word.sample[ch] = bits[ch] ? SAMPLE_POS_ONE : SAMPLE_NEG_ONE;
         end else if (bad) begin
            word.bad = 1'b1;
         end else begin
            mono = signed_weight(bits[2], centre_cfg);
            if (six) mono += signed_weight(bits[3], sub_cfg);
            left  = signed_weight(bits[0], front_cfg) +
                    signed_weight(bits[rear_l], rear_cfg) + mono;
            right = signed_weight(bits[1], front_cfg) +
                    signed_weight(bits[rear_r], rear_cfg) + mono;
            word.sample[0] = scale_to_sample(left);
            word.sample[1] = scale_to_sample(right);
         end
         word.last = (pos == 7);
         pending_words.push_back(word);
      end
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name,
                                       input logic signed [SAMPLE_W-1:0] want,
                                       input logic signed [SAMPLE_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_words
      bit_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: rsp word with none expected, expected nothing, actual %0d %0d",
                     $time, rsp_out0, rsp_out1);
         end else begin
            want = pending_words.pop_front();
            check_field("out0", want.sample[0], rsp_out0);
            check_field("out1", want.sample[1], rsp_out1);
            check_field("out2", want.sample[2], rsp_out2);
            check_field("out3", want.sample[3], rsp_out3);
            check_field("out4", want.sample[4], rsp_out4);
            check_field("out5", want.sample[5], rsp_out5);
            check_field("bad_setup", SAMPLE_W'(want.bad), SAMPLE_W'(rsp_bad_setup));
            check_field("last_of_frame", SAMPLE_W'(want.last),
                        SAMPLE_W'(rsp_last_of_frame));
         end
      end
   end

   // rsp_ready: random stalls, plus one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (rx_bursts && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // one register write, the model copy follows at acceptance
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIX_MODE:      mode_cfg   = value[0];
         CSR_CHANNEL_COUNT: count_cfg  = value[CHCOUNT_W-1:0];
         CSR_FRONT_WEIGHT:  front_cfg  = value[WEIGHT_W-1:0];
         CSR_CENTRE_WEIGHT: centre_cfg = value[WEIGHT_W-1:0];
         CSR_SUB_WEIGHT:    sub_cfg    = value[WEIGHT_W-1:0];
         CSR_REAR_WEIGHT:   rear_cfg   = value[WEIGHT_W-1:0];
         CSR_MIX_GAIN:      gain_cfg   = value[GAIN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // offer one frame word, hold it until taken, then maybe idle
   task automatic send_frame(input frame_type frame);
      req_valid      <= 1'b1;
      req_chan0_byte <= frame[0];
      req_chan1_byte <= frame[1];
      req_chan2_byte <= frame[2];
      req_chan3_byte <= frame[3];
      req_chan4_byte <= frame[4];
      req_chan5_byte <= frame[5];
      do @(posedge clock); while (!req_ready);
      predict_frame(frame);
      if (tx_bursts && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding word
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic frame_type random_frame();
      frame_type frame;
      for (int ch = 0; ch < NUM_CHANNELS; ch++)
         frame[ch] = BYTE_W'($urandom);
      return frame;
   endfunction

   // random register set, garbage in the unused data bits
   task automatic load_random_setup();
      logic [WEIGHT_W-1:0]  w [4];
      logic                 mode;
      logic [CHCOUNT_W-1:0] count;
      logic [CSR_DAT_W-1:0] gain;
      longint               total;
      mode = 1'($urandom_range(0, 1));
      if (mode && $urandom_range(0, 4) != 0)
         count = $urandom_range(0, 1) ? CH_FIVE : CH_SIX;
      else
         count = CHCOUNT_W'($urandom_range(0, 7));
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(0, 5))
            0:       w[k] = '0;
            1:       w[k] = 16'd32768;
            2:       w[k] = 16'hFFFF;
            default: w[k] = WEIGHT_W'($urandom_range(0, 32768));
         endcase
      end
      // front, centre, sub, rear as one side of the mix sees them
      total = longint'(w[0]) + longint'(w[1]) + longint'(w[3]) +
              ((count == CH_SIX) ? longint'(w[2]) : 0);
      case ($urandom_range(0, 4))
         0, 1: begin
            if (total == 0) gain = 20'd65536;
            else if ((64'sd2147483648 / total) > 20'hFFFFF) gain = 20'hFFFFF;
            else gain = CSR_DAT_W'(64'sd2147483648 / total);
         end
         2:       gain = CSR_DAT_W'($urandom);
         3:       gain = 20'hFFFFF;
         default: gain = 20'd65536;
      endcase
      write_reg(CSR_MIX_MODE, {19'($urandom), mode});
      write_reg(CSR_CHANNEL_COUNT, {17'($urandom), count});
      write_reg(CSR_FRONT_WEIGHT, {4'($urandom), w[0]});
      write_reg(CSR_CENTRE_WEIGHT, {4'($urandom), w[1]});
      write_reg(CSR_SUB_WEIGHT, {4'($urandom), w[2]});
      write_reg(CSR_REAR_WEIGHT, {4'($urandom), w[3]});
      write_reg(CSR_MIX_GAIN, gain);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // unpack mode from reset, then short and over-range channel counts
   task automatic test_unpack_directed();
      send_frame({NUM_CHANNELS{8'h00}});
      send_frame({NUM_CHANNELS{8'hFF}});
      send_frame({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
      send_frame({8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h81});
      pause_until_drained();
      write_reg(CSR_CHANNEL_COUNT, 20'd0);
      send_frame({NUM_CHANNELS{8'hA5}});
      pause_until_drained();
      write_reg(CSR_CHANNEL_COUNT, 20'd1);
      send_frame({NUM_CHANNELS{8'h3C}});
      pause_until_drained();
      write_reg(CSR_CHANNEL_COUNT, 20'd7);
      send_frame({8'hC3, 8'h5A, 8'h0F, 8'hF0, 8'h69, 8'h96});
      pause_until_drained();
   endtask

   // downmix: both layouts, bad counts, saturation, zero weights, rounding ties, zero gain
   task automatic test_mix_directed();
      write_reg(CSR_SPARE_INDEX, 20'hFFFFF);
      write_reg(CSR_MIX_MODE, 20'd1);
      write_reg(CSR_CHANNEL_COUNT, 20'd6);
      send_frame({NUM_CHANNELS{8'h00}});
      send_frame({NUM_CHANNELS{8'hFF}});
      // rear right, rear left, sub, centre, right, left
      send_frame({8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h00, 8'hFF});
      pause_until_drained();
      write_reg(CSR_CHANNEL_COUNT, 20'd5);
      send_frame({NUM_CHANNELS{8'hFF}});
      send_frame({8'h99, 8'h33, 8'hCC, 8'hF0, 8'h0F, 8'h66});
      pause_until_drained();

      // mix with a channel count that has no layout
      write_reg(CSR_CHANNEL_COUNT, 20'd4);
      send_frame(random_frame());
      pause_until_drained();
      write_reg(CSR_CHANNEL_COUNT, 20'd0);
      send_frame(random_frame());
      pause_until_drained();
      write_reg(CSR_CHANNEL_COUNT, 20'd7);
      send_frame(random_frame());
      pause_until_drained();

      // heaviest weights and gain drive both rails
      write_reg(CSR_CHANNEL_COUNT, 20'd6);
      write_reg(CSR_FRONT_WEIGHT, 20'hFFFFF);
      write_reg(CSR_CENTRE_WEIGHT, 20'hFFFFF);
      write_reg(CSR_SUB_WEIGHT, 20'hFFFFF);
      write_reg(CSR_REAR_WEIGHT, 20'hFFFFF);
      write_reg(CSR_MIX_GAIN, 20'hFFFFF);
      send_frame({NUM_CHANNELS{8'hFF}});
      send_frame({NUM_CHANNELS{8'h00}});
      pause_until_drained();

      // all weights off gives silence
      write_reg(CSR_FRONT_WEIGHT, 20'd0);
      write_reg(CSR_CENTRE_WEIGHT, 20'd0);
      write_reg(CSR_SUB_WEIGHT, 20'd0);
      write_reg(CSR_REAR_WEIGHT, 20'd0);
      send_frame(random_frame());
      pause_until_drained();

      // half an lsb either way must round away from zero
      write_reg(CSR_CHANNEL_COUNT, 20'd5);
      write_reg(CSR_FRONT_WEIGHT, 20'd1);
      write_reg(CSR_MIX_GAIN, 20'd32768);
      send_frame({8'h00, 8'h00, 8'h00, 8'h00, 8'h55, 8'hAA});
      pause_until_drained();

      // zero gain
      write_reg(CSR_FRONT_WEIGHT, 20'd32768);
      write_reg(CSR_REAR_WEIGHT, 20'd32768);
      write_reg(CSR_MIX_GAIN, 20'd0);
      send_frame(random_frame());
      pause_until_drained();
   endtask

   // random settings, random frames, idling on both sides
   task automatic test_random_phases();
      int count;
      tx_bursts = 1'b1;
      rx_bursts = 1'b1;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_setup();
         count = $urandom_range(15, 35);
         repeat (count) send_frame(random_frame());
         pause_until_drained();
      end
   endtask

   // output held off long enough for the unit to back up into req_ready
   task automatic test_output_stall();
      load_random_setup();
      tx_bursts     = 1'b0;
      long_hold_req = 1'b1;
      repeat (30) send_frame(random_frame());
      pause_until_drained();
   endtask

   // no idling at all: frames back to back at full rate
   task automatic test_full_rate();
      write_reg(CSR_MIX_MODE, 20'd1);
      write_reg(CSR_CHANNEL_COUNT, 20'd6);
      write_reg(CSR_FRONT_WEIGHT, 20'd32768);
      write_reg(CSR_CENTRE_WEIGHT, 20'd23170);
      write_reg(CSR_SUB_WEIGHT, 20'd23170);
      write_reg(CSR_REAR_WEIGHT, 20'd32768);
      write_reg(CSR_MIX_GAIN, 20'd19195);
      tx_bursts = 1'b0;
      rx_bursts = 1'b0;
      repeat (40) send_frame(random_frame());
      req_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      errors        = 0;
      tx_bursts     = 1'b0;
      rx_bursts     = 1'b0;
      long_hold_req = 1'b0;
      mode_cfg      = 1'b0;
      count_cfg     = RST_CHANNEL_COUNT;
      front_cfg     = RST_FRONT_WEIGHT;
      centre_cfg    = RST_CENTRE_WEIGHT;
      sub_cfg       = RST_SUB_WEIGHT;
      rear_cfg      = RST_REAR_WEIGHT;
      gain_cfg      = RST_MIX_GAIN;

      reset          <= 1'b1;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      req_valid      <= 1'b0;
      req_chan0_byte <= '0;
      req_chan1_byte <= '0;
      req_chan2_byte <= '0;
      req_chan3_byte <= '0;
      req_chan4_byte <= '0;
      req_chan5_byte <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_unpack_directed();
      test_mix_directed();
      test_random_phases();
      test_output_stall();
      test_full_rate();

      // let the last words out, then watch for strays
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
